@@ hdl/sobel_kernel_generator_unit_macros.svh @@
// Assertion macros for the Sobel kernel generator.
// Every macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SOBEL_KERNEL_GENERATOR_UNIT_MACROS_SVH
`define SOBEL_KERNEL_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define SKG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SKG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/skg_pkg.sv @@
// Shared types and constants for the Sobel kernel generator.
// No dependencies; imported by skg_pass_unit and the top level.
package skg_pkg;

  localparam int unsigned SizeW            = 5;
  localparam int unsigned CoefW            = 32;
  localparam int unsigned CfgAddrW         = 3;
  localparam int unsigned CfgDataW         = 32;
  localparam int unsigned MaxKernelSizeDef = 31;

  localparam logic [SizeW-1:0] RaisedSize  = SizeW'(3);
  localparam logic [SizeW-1:0] ResetKSize  = SizeW'(3);

  // register numbers (address bit 2)
  localparam logic RegKernelSize = 1'b0;
  localparam logic RegNormalize  = 1'b1;

  typedef struct packed {
    logic wb;      // writeback of one row entry this cycle
    logic first;   // entry 0: left neighbor is zero
    logic smooth;  // 1: binomial add, 0: difference
  } pass_ctl_t;

endpackage

@@ hdl/skg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module skg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/skg_pass_unit.sv @@
// Shared add/subtract unit for the smoothing and difference passes.
// Depends on skg_pkg (pass_ctl_t, CoefW).
module skg_pass_unit (
  input  logic                        clk_i,
  input  skg_pkg::pass_ctl_t          ctl_i,
  input  logic [skg_pkg::CoefW-1:0]   rdata_i,
  output logic [skg_pkg::CoefW-1:0]   result_o
);
  import skg_pkg::*;

  logic [CoefW-1:0] prev_q;  // old value of entry j-1
  logic [CoefW-1:0] opa;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wb) begin
      prev_q <= rdata_i;
    end
  end

  assign opa      = ctl_i.first ? '0 : prev_q;
  // smooth: new[j] = row[j] + row[j-1]; difference: new[j] = row[j-1] - row[j]
  assign result_o = ctl_i.smooth ? (opa + rdata_i) : (opa - rdata_i);

endmodule

@@ hdl/sobel_kernel_generator_unit.sv @@
// Sobel derivative kernel generator: one request in, separable taps out.
// Channels: request (order_x_i, order_y_i) on in_valid_i/in_stall_o; taps on
// out_valid_o/out_stall_i, all x taps then all y taps, last_o on the final one.
// An order not below its axis size gives one error result instead.
// Config over an APB-style port: kernel_size at 0x0, normalize_mode at 0x4.
// Each axis builds its row in a small RAM: a fill sweep over its S entries,
// then S-1 passes through one shared add/subtract unit, then a read and an
// emit for each tap. A new request is taken only once the previous one has
// placed its last result in the output register.
// The output register holds its transfer while out_stall_i is high; the
// sequencer waits. Reset returns to idle, kernel_size 3, normalize off,
// output empty; the RAM needs no clearing since every row is written first.
// Depends on skg_pkg, skg_ram, skg_pass_unit.
`include "sobel_kernel_generator_unit_macros.svh"

module sobel_kernel_generator_unit #(
  parameter int unsigned MAX_KERNEL_SIZE = skg_pkg::MaxKernelSizeDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [skg_pkg::SizeW-1:0]      order_x_i,
  input  logic [skg_pkg::SizeW-1:0]      order_y_i,
  // taps
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           axis_o,
  output logic [skg_pkg::SizeW-1:0]      tap_index_o,
  output logic signed [skg_pkg::CoefW-1:0] coefficient_o,
  output logic [skg_pkg::SizeW-1:0]      scale_shift_o,
  output logic                           order_error_o,
  output logic                           last_o,
  // config
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [skg_pkg::CfgAddrW-1:0]   paddr,
  input  logic [skg_pkg::CfgDataW-1:0]   pwdata,
  output logic [skg_pkg::CfgDataW-1:0]   prdata,
  output logic                           pready
);
  import skg_pkg::*;

  localparam int unsigned RamAw = (MAX_KERNEL_SIZE > 1) ? $clog2(MAX_KERNEL_SIZE) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_INIT,
    S_PASS,
    S_EMIT_RD,
    S_EMIT_LD
  } state_e;

  state_e           state_q;
  logic [SizeW-1:0] kernel_size_q;
  logic             normalize_q;
  logic             axis_q;
  logic [SizeW-1:0] j_q;       // fill / read-issue / emit index
  logic [SizeW-1:0] wj_q;      // writeback index of a pass
  logic             wb_v_q;
  logic [SizeW-1:0] pass_q;
  logic [SizeW-1:0] sx_q, sy_q, ox_q, oy_q;

  logic             out_valid_q, axis_out_q, err_q, last_q;
  logic [SizeW-1:0] tap_q, shift_q;
  logic [CoefW-1:0] coef_q;

  logic [SizeW-1:0] ksize, sx_in, sy_in, cur_size, cur_order, smooth_cnt;
  logic             err_in, in_acc, out_free, issue, cfg_wr, reg_idx;
  pass_ctl_t        ctl;
  logic             ram_we;
  logic [RamAw-1:0] ram_waddr, ram_raddr;
  logic [CoefW-1:0] ram_wdata, ram_rdata, alu_res;

  // config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[CfgAddrW-1];
  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = (reg_idx == RegNormalize) ? CfgDataW'(normalize_q)
                                             : CfgDataW'(kernel_size_q);

  // per-axis sizes
  assign ksize  = (kernel_size_q > SizeW'(MAX_KERNEL_SIZE)) ? SizeW'(MAX_KERNEL_SIZE)
                                                            : kernel_size_q;
  assign sx_in  = (ksize == SizeW'(1) && order_x_i != '0) ? RaisedSize : ksize;
  assign sy_in  = (ksize == SizeW'(1) && order_y_i != '0) ? RaisedSize : ksize;
  assign err_in = (order_x_i >= sx_in) || (order_y_i >= sy_in);

  assign cur_size   = axis_q ? sy_q : sx_q;
  assign cur_order  = axis_q ? oy_q : ox_q;
  assign smooth_cnt = cur_size - cur_order - SizeW'(1);
  assign issue      = (j_q != cur_size);

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // shared pass unit
  assign ctl.wb     = wb_v_q;
  assign ctl.first  = (wj_q == '0);
  assign ctl.smooth = (pass_q < smooth_cnt);

  skg_pass_unit u_pass (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .rdata_i  (ram_rdata),
    .result_o (alu_res)
  );

  assign ram_we    = (state_q == S_INIT) || wb_v_q;
  assign ram_waddr = (state_q == S_INIT) ? j_q[RamAw-1:0] : wj_q[RamAw-1:0];
  assign ram_wdata = (state_q == S_INIT) ? ((j_q == '0) ? CoefW'(1) : '0) : alu_res;
  assign ram_raddr = j_q[RamAw-1:0];

  skg_ram #(
    .WIDTH (CoefW),
    .DEPTH (MAX_KERNEL_SIZE)
  ) u_row (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      kernel_size_q <= ResetKSize;
      normalize_q   <= 1'b0;
      axis_q        <= 1'b0;
      j_q           <= '0;
      wj_q          <= '0;
      wb_v_q        <= 1'b0;
      pass_q        <= '0;
      sx_q          <= '0;
      sy_q          <= '0;
      ox_q          <= '0;
      oy_q          <= '0;
      out_valid_q   <= 1'b0;
      axis_out_q    <= 1'b0;
      tap_q         <= '0;
      coef_q        <= '0;
      shift_q       <= '0;
      err_q         <= 1'b0;
      last_q        <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx)
          RegKernelSize: kernel_size_q <= pwdata[SizeW-1:0];
          RegNormalize:  normalize_q   <= pwdata[0];
          default:       ;
        endcase
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      wb_v_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            sx_q   <= sx_in;
            sy_q   <= sy_in;
            ox_q   <= order_x_i;
            oy_q   <= order_y_i;
            axis_q <= 1'b0;
            j_q    <= '0;
            pass_q <= '0;
            state_q <= err_in ? S_ERR : S_INIT;
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            axis_out_q  <= 1'b0;
            tap_q       <= '0;
            coef_q      <= '0;
            shift_q     <= '0;
            err_q       <= 1'b1;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_INIT: begin
          if (j_q == cur_size - SizeW'(1)) begin
            j_q     <= '0;
            pass_q  <= '0;
            state_q <= (cur_size == SizeW'(1)) ? S_EMIT_RD : S_PASS;
          end else begin
            j_q <= j_q + SizeW'(1);
          end
        end
        S_PASS: begin
          if (issue) begin
            wj_q   <= j_q;
            wb_v_q <= 1'b1;
            j_q    <= j_q + SizeW'(1);
          end else if (!wb_v_q) begin
            // pass drained; next read of entry 0 comes after the last write
            j_q <= '0;
            if (pass_q == cur_size - SizeW'(2)) begin
              pass_q  <= '0;
              state_q <= S_EMIT_RD;
            end else begin
              pass_q <= pass_q + SizeW'(1);
            end
          end
        end
        S_EMIT_RD: begin
          state_q <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            axis_out_q  <= axis_q;
            tap_q       <= j_q;
            coef_q      <= ram_rdata;
            shift_q     <= normalize_q ? smooth_cnt : '0;
            err_q       <= 1'b0;
            last_q      <= axis_q && (j_q == cur_size - SizeW'(1));
            if (j_q == cur_size - SizeW'(1)) begin
              j_q <= '0;
              if (axis_q) begin
                axis_q  <= 1'b0;
                state_q <= S_IDLE;
              end else begin
                axis_q  <= 1'b1;
                state_q <= S_INIT;
              end
            end else begin
              j_q     <= j_q + SizeW'(1);
              state_q <= S_EMIT_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign axis_o        = axis_out_q;
  assign tap_index_o   = tap_q;
  assign coefficient_o = coef_q;
  assign scale_shift_o = shift_q;
  assign order_error_o = err_q;
  assign last_o        = last_q;

  `SKG_ASSERT_IMP(a_err_shape, out_valid_o && order_error_o, last_o && !axis_o && (coefficient_o == '0), "error transfer malformed")
  `SKG_ASSERT_IMP(a_last_on_y, out_valid_o && last_o && !order_error_o, axis_o, "last flag on an x tap")
  `SKG_ASSERT_NXT(a_accept_busy, in_valid_i && !in_stall_o, state_q != S_IDLE, "request taken but sequencer idle")
  `SKG_ASSERT_IMP(a_no_wb_emit, state_q == S_EMIT_RD || state_q == S_EMIT_LD, !wb_v_q, "row write during emit")
  `SKG_ASSERT_IMP(a_idx_bound, state_q != S_IDLE, j_q <= cur_size, "row index past kernel size")

endmodule
